// ===== sv/ncmc_pkg.sv =====
// Shared widths, register codes and label colors for the nearest class mean classifier.
package ncmc_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int BAND_W      = 15;
  localparam int NUM_BANDS   = 3;
  localparam int MEAN_W      = BAND_W * NUM_BANDS;
  localparam int SQ_W        = 2 * BAND_W;
  localparam int DIST_W      = 32;
  localparam int LIMIT_W     = 32;
  localparam int IDX_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int MAX_CLASSES = 5;
  localparam int COLOR_W     = 8;

  localparam logic [BAND_W-1:0]    SCALE     = 15'd100;
  localparam logic [LIMIT_W-1:0]   LIMIT_RST = 32'd1000000000;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd5;

  // band order inside a mean word
  localparam int BAND_RED   = 0;
  localparam int BAND_GREEN = 1;
  localparam int BAND_BLUE  = 2;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [BAND_W-1:0]   band_t;
  typedef logic [MEAN_W-1:0]   mean_t;
  typedef logic [SQ_W-1:0]     sq_t;
  typedef logic [DIST_W-1:0]   dist_t;
  typedef logic [IDX_W-1:0]    idx_t;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } label_t;

  function automatic label_t label_of(idx_t idx);
    label_t lbl;
    case (idx)
      3'd0:    lbl = '{blue: 8'd255, green: 8'd0,   red: 8'd0};
      3'd1:    lbl = '{blue: 8'd0,   green: 8'd255, red: 8'd0};
      3'd2:    lbl = '{blue: 8'd0,   green: 8'd255, red: 8'd255};
      3'd3:    lbl = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
      3'd4:    lbl = '{blue: 8'd45,  green: 8'd82,  red: 8'd160};
      default: lbl = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
    endcase
    return lbl;
  endfunction

endpackage

// ===== sv/ncmc_dist.sv =====
// Distance lanes: scale, absolute difference, square and band sum, one register stage each.
module ncmc_dist #(
  parameter int NUM_CLASSES = 5
) (
  input  logic                    clk,
  input  logic [3:0]              en,
  input  ncmc_pkg::sample_t       pixel_red,
  input  ncmc_pkg::sample_t       pixel_green,
  input  ncmc_pkg::sample_t       pixel_blue,
  input  ncmc_pkg::mean_t         mean [NUM_CLASSES],
  output ncmc_pkg::dist_t         sq_dist [NUM_CLASSES]
);

  localparam int NB = ncmc_pkg::NUM_BANDS;

  ncmc_pkg::band_t scl_r   [NB];
  ncmc_pkg::band_t scl_nxt [NB];
  ncmc_pkg::band_t dif_r   [NUM_CLASSES][NB];
  ncmc_pkg::band_t dif_nxt [NUM_CLASSES][NB];
  ncmc_pkg::sq_t   sq_r    [NUM_CLASSES][NB];
  ncmc_pkg::sq_t   sq_nxt  [NUM_CLASSES][NB];
  ncmc_pkg::dist_t dist_r  [NUM_CLASSES];
  ncmc_pkg::dist_t dist_nxt[NUM_CLASSES];

  // stage 1: samples in hundredths
  always_comb begin
    scl_nxt[ncmc_pkg::BAND_RED]   = ncmc_pkg::BAND_W'(pixel_red)   * ncmc_pkg::SCALE;
    scl_nxt[ncmc_pkg::BAND_GREEN] = ncmc_pkg::BAND_W'(pixel_green) * ncmc_pkg::SCALE;
    scl_nxt[ncmc_pkg::BAND_BLUE]  = ncmc_pkg::BAND_W'(pixel_blue)  * ncmc_pkg::SCALE;
  end

  // stage 2: absolute difference to each band of each mean
  always_comb begin
    ncmc_pkg::band_t m;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      for (int b = 0; b < NB; b++) begin
        m = mean[k][b*ncmc_pkg::BAND_W +: ncmc_pkg::BAND_W];
        dif_nxt[k][b] = (scl_r[b] >= m) ? (scl_r[b] - m) : (m - scl_r[b]);
      end
    end
  end

  // stage 3: squares
  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      for (int b = 0; b < NB; b++) begin
        sq_nxt[k][b] = ncmc_pkg::SQ_W'(dif_r[k][b]) * ncmc_pkg::SQ_W'(dif_r[k][b]);
      end
    end
  end

  // stage 4: band sum, fits 32 bits without loss
  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      dist_nxt[k] = ncmc_pkg::DIST_W'(sq_r[k][0]) + ncmc_pkg::DIST_W'(sq_r[k][1])
                  + ncmc_pkg::DIST_W'(sq_r[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      scl_r <= scl_nxt;
    end
    if (en[1]) begin
      dif_r <= dif_nxt;
    end
    if (en[2]) begin
      sq_r <= sq_nxt;
    end
    if (en[3]) begin
      dist_r <= dist_nxt;
    end
  end

  assign sq_dist = dist_r;

endmodule

// ===== sv/ncmc_select.sv =====
// Compare chain, one class per stage, then the output word with its label color.
module ncmc_select #(
  parameter int NUM_CLASSES = 5
) (
  input  logic                               clk,
  input  logic [NUM_CLASSES:0]               en,
  input  ncmc_pkg::dist_t                    sq_dist [NUM_CLASSES],
  input  logic [ncmc_pkg::LIMIT_W-1:0]       limit,
  output ncmc_pkg::idx_t                     class_index,
  output logic                               no_match,
  output logic [ncmc_pkg::COLOR_W-1:0]       label_blue,
  output logic [ncmc_pkg::COLOR_W-1:0]       label_green,
  output logic [ncmc_pkg::COLOR_W-1:0]       label_red
);

  // per stage: running best, winner, hit flag and the distances still to check
  ncmc_pkg::dist_t best_in  [NUM_CLASSES];
  ncmc_pkg::idx_t  win_in   [NUM_CLASSES];
  logic            hit_in   [NUM_CLASSES];
  ncmc_pkg::dist_t dl_in    [NUM_CLASSES][NUM_CLASSES];

  ncmc_pkg::dist_t best_r   [NUM_CLASSES];
  ncmc_pkg::dist_t best_nxt [NUM_CLASSES];
  ncmc_pkg::idx_t  win_r    [NUM_CLASSES];
  ncmc_pkg::idx_t  win_nxt  [NUM_CLASSES];
  logic            hit_r    [NUM_CLASSES];
  logic            hit_nxt  [NUM_CLASSES];
  ncmc_pkg::dist_t dl_r     [NUM_CLASSES][NUM_CLASSES];

  ncmc_pkg::idx_t  idx_r,  idx_nxt;
  logic            nom_r,  nom_nxt;
  ncmc_pkg::label_t lbl_r, lbl_nxt;

  always_comb begin
    best_in[0] = ncmc_pkg::DIST_W'(limit);
    win_in[0]  = '0;
    hit_in[0]  = 1'b0;
    dl_in[0]   = sq_dist;
    for (int k = 1; k < NUM_CLASSES; k++) begin
      best_in[k] = best_r[k-1];
      win_in[k]  = win_r[k-1];
      hit_in[k]  = hit_r[k-1];
      dl_in[k]   = dl_r[k-1];
    end
  end

  // strictly smaller wins, so ties keep the lower class
  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (dl_in[k][k] < best_in[k]) begin
        best_nxt[k] = dl_in[k][k];
        win_nxt[k]  = ncmc_pkg::IDX_W'(k);
        hit_nxt[k]  = 1'b1;
      end else begin
        best_nxt[k] = best_in[k];
        win_nxt[k]  = win_in[k];
        hit_nxt[k]  = hit_in[k];
      end
    end
  end

  always_comb begin
    if (hit_r[NUM_CLASSES-1]) begin
      idx_nxt = win_r[NUM_CLASSES-1];
      nom_nxt = 1'b0;
      lbl_nxt = ncmc_pkg::label_of(win_r[NUM_CLASSES-1]);
    end else begin
      idx_nxt = '0;
      nom_nxt = 1'b1;
      lbl_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (en[k]) begin
        best_r[k] <= best_nxt[k];
        win_r[k]  <= win_nxt[k];
        hit_r[k]  <= hit_nxt[k];
        dl_r[k]   <= dl_in[k];
      end
    end
    if (en[NUM_CLASSES]) begin
      idx_r <= idx_nxt;
      nom_r <= nom_nxt;
      lbl_r <= lbl_nxt;
    end
  end

  assign class_index = idx_r;
  assign no_match    = nom_r;
  assign label_blue  = lbl_r.blue;
  assign label_green = lbl_r.green;
  assign label_red   = lbl_r.red;

endmodule

// ===== sv/nearest_class_mean_pixel_classifier.sv =====
// Top level: config registers, stage valid and ready chain, distance and compare pipelines.
//
//   channel | direction | handshake             | word
//   in_     | input     | in_valid / in_ready   | pixel_red, pixel_green, pixel_blue
//   out_    | output    | out_valid / out_ready | class_index, no_match, label_blue/green/red
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_wdata (always ready)
//
// One word per cycle while out_ready is high; four distance stages, one compare stage
// per class and one output register.
// Each stage has its own valid bit; a stage loads when it is empty or the stage
// below moves, so bubbles close up and input is taken while a result waits.
// Reset clears the valid bits and loads the config registers (means 0, limit 1e9).
module nearest_class_mean_pixel_classifier #(
  parameter int NUM_CLASSES = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ncmc_pkg::SAMPLE_W-1:0]       in_pixel_red,
  input  logic [ncmc_pkg::SAMPLE_W-1:0]       in_pixel_green,
  input  logic [ncmc_pkg::SAMPLE_W-1:0]       in_pixel_blue,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ncmc_pkg::IDX_W-1:0]          out_class_index,
  output logic                                out_no_match,
  output logic [ncmc_pkg::COLOR_W-1:0]        out_label_blue,
  output logic [ncmc_pkg::COLOR_W-1:0]        out_label_green,
  output logic [ncmc_pkg::COLOR_W-1:0]        out_label_red,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ncmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ncmc_pkg::MEAN_W-1:0]         cfg_wdata
);

  localparam int DIST_STAGES = 4;
  localparam int NS          = DIST_STAGES + NUM_CLASSES + 1;

  ncmc_pkg::mean_t                mean_r   [NUM_CLASSES];
  ncmc_pkg::mean_t                mean_nxt [NUM_CLASSES];
  logic [ncmc_pkg::LIMIT_W-1:0]   limit_r, limit_nxt;
  logic [NS-1:0]                  vld_r, vld_nxt;
  logic [NS:0]                    rdy;
  ncmc_pkg::dist_t                sq_dist [NUM_CLASSES];

  assign cfg_ready = 1'b1;

  always_comb begin
    mean_nxt  = mean_r;
    limit_nxt = limit_r;
    if (cfg_valid) begin
      if (cfg_index == ncmc_pkg::REG_LIMIT) begin
        limit_nxt = cfg_wdata[ncmc_pkg::LIMIT_W-1:0];
      end
      for (int k = 0; k < NUM_CLASSES; k++) begin
        if (cfg_index == ncmc_pkg::CFG_IDX_W'(k)) begin
          mean_nxt[k] = cfg_wdata;
        end
      end
    end
  end

  // ready ripples up from the output; a stage moves when empty or drained below
  always_comb begin
    rdy[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
  end

  always_comb begin
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int s = 1; s < NS; s++) begin
      vld_nxt[s] = rdy[s] ? vld_r[s-1] : vld_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      limit_r <= ncmc_pkg::LIMIT_RST;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        mean_r[k] <= '0;
      end
    end else begin
      vld_r   <= vld_nxt;
      limit_r <= limit_nxt;
      mean_r  <= mean_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NS-1];

  ncmc_dist #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dist (
    .clk         (clk),
    .en          (rdy[DIST_STAGES-1:0]),
    .pixel_red   (in_pixel_red),
    .pixel_green (in_pixel_green),
    .pixel_blue  (in_pixel_blue),
    .mean        (mean_r),
    .sq_dist     (sq_dist)
  );

  ncmc_select #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_select (
    .clk         (clk),
    .en          (rdy[NS-1:DIST_STAGES]),
    .sq_dist     (sq_dist),
    .limit       (limit_r),
    .class_index (out_class_index),
    .no_match    (out_no_match),
    .label_blue  (out_label_blue),
    .label_green (out_label_green),
    .label_red   (out_label_red)
  );

`ifndef SYNTHESIS
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_match |-> out_class_index == '0 && out_label_blue == '0
      && out_label_green == '0 && out_label_red == '0)
    else $error("no-match word carries a nonzero index or color");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_no_match |-> out_class_index < ncmc_pkg::IDX_W'(NUM_CLASSES))
    else $error("class index beyond configured class count");

  a_label_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_no_match |->
      {out_label_blue, out_label_green, out_label_red} ==
      ncmc_pkg::label_of(out_class_index))
    else $error("label color does not match class index");

  a_stall_keeps_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && vld_r[NS-2] |=> vld_r[NS-2] && out_valid)
    else $error("word behind a stalled output was dropped");
`endif

endmodule

// ===== test/nearest_class_mean_pixel_classifier_tb.sv =====
// Self-checking testbench for the nearest class mean pixel classifier.
module nearest_class_mean_pixel_classifier_tb;

  localparam int NUM_CLASSES     = 5;
  localparam int LATENCY         = NUM_CLASSES + 5;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int HOLD_PHASE      = 3;
  localparam int HOLD_CYCLES     = 80;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SCALE           = 100;
  localparam logic [31:0] RESET_REJECT_LIMIT = 32'd1000000000;

  // indexes 6 and 7 address nothing and must leave every register alone
  typedef enum logic [2:0] {
    CFG_MEAN_0, CFG_MEAN_1, CFG_MEAN_2, CFG_MEAN_3, CFG_MEAN_4,
    CFG_REJECT_LIMIT, CFG_SPARE_6, CFG_SPARE_7
  } cfg_reg_e;

  typedef enum logic [1:0] {ROW_PIXEL, ROW_PIXEL_KNOWN, ROW_REG_WRITE} row_kind_e;

  typedef struct packed {
    logic [2:0] class_index;
    logic       no_match;
    logic [7:0] label_blue;
    logic [7:0] label_green;
    logic [7:0] label_red;
  } class_result_t;

  typedef struct packed {
    row_kind_e          kind;
    cfg_reg_e           reg_sel;
    ncmc_pkg::mean_t    wdata;
    ncmc_pkg::sample_t  red;
    ncmc_pkg::sample_t  green;
    ncmc_pkg::sample_t  blue;
    class_result_t      known;
  } stim_row_t;

  // label colors packed blue, green, red
  localparam logic [23:0] LABEL_BGR [5] = '{
    24'hFF0000, 24'h00FF00, 24'h00FFFF, 24'h000000, 24'h2D52A0
  };

  localparam class_result_t RESULT_UNUSED   = '0;
  localparam class_result_t RESULT_NO_MATCH = '{class_index: 3'd0, no_match: 1'b1,
                                                label_blue: 8'd0, label_green: 8'd0,
                                                label_red: 8'd0};
  localparam class_result_t RESULT_CLASS_0  = '{class_index: 3'd0, no_match: 1'b0,
                                                label_blue: 8'hFF, label_green: 8'd0,
                                                label_red: 8'd0};
  localparam ncmc_pkg::mean_t NO_DATA  = '0;
  localparam ncmc_pkg::mean_t ALL_ONES = {45{1'b1}};

  localparam int DIRECTED_COUNT = 28;
  // means are {blue, green, red} in hundredths
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{ROW_PIXEL_KNOWN, CFG_MEAN_0, NO_DATA, 8'd0, 8'd0, 8'd0, RESULT_CLASS_0},
    '{ROW_PIXEL_KNOWN, CFG_MEAN_0, NO_DATA, 8'd255, 8'd255, 8'd255, RESULT_NO_MATCH},
    '{ROW_PIXEL, CFG_MEAN_0, NO_DATA, 8'd255, 8'd0, 8'd0, RESULT_UNUSED},
    '{ROW_PIXEL, CFG_MEAN_0, NO_DATA, 8'd100, 8'd100, 8'd100, RESULT_UNUSED},
    '{ROW_REG_WRITE, CFG_MEAN_0, {15'd5000, 15'd5000, 15'd5000}, 8'd0, 8'd0, 8'd0,
      RESULT_UNUSED},
    '{ROW_REG_WRITE, CFG_MEAN_1, {15'd5000, 15'd5000, 15'd20000}, 8'd0, 8'd0, 8'd0,
      RESULT_UNUSED},
    '{ROW_REG_WRITE, CFG_MEAN_2, {15'd5000, 15'd20000, 15'd5000}, 8'd0, 8'd0, 8'd0,
      RESULT_UNUSED},
    '{ROW_REG_WRITE, CFG_MEAN_3, {15'd20000, 15'd5000, 15'd5000}, 8'd0, 8'd0, 8'd0,
      RESULT_UNUSED},
    '{ROW_REG_WRITE, CFG_MEAN_4, {15'd20000, 15'd20000, 15'd20000}, 8'd0, 8'd0, 8'd0,
      RESULT_UNUSED},
    '{ROW_PIXEL, CFG_MEAN_0, NO_DATA, 8'd50, 8'd50, 8'd50, RESULT_UNUSED},
    '{ROW_PIXEL, CFG_MEAN_0, NO_DATA, 8'd200, 8'd50, 8'd50, RESULT_UNUSED},
    '{ROW_PIXEL, CFG_MEAN_0, NO_DATA, 8'd50, 8'd200, 8'd50, RESULT_UNUSED},
    '{ROW_PIXEL, CFG_MEAN_0, NO_DATA, 8'd50, 8'd50, 8'd200, RESULT_UNUSED},
    '{ROW_PIXEL, CFG_MEAN_0, NO_DATA, 8'd200, 8'd200, 8'd200, RESULT_UNUSED},
    // equal distances: the lowest class has to win
    '{ROW_PIXEL, CFG_MEAN_0, NO_DATA, 8'd125, 8'd50, 8'd50, RESULT_UNUSED},
    '{ROW_PIXEL, CFG_MEAN_0, NO_DATA, 8'd125, 8'd125, 8'd50, RESULT_UNUSED},
    '{ROW_PIXEL, CFG_MEAN_0, NO_DATA, 8'd200, 8'd200, 8'd50, RESULT_UNUSED},
    '{ROW_REG_WRITE, CFG_SPARE_6, ALL_ONES, 8'd0, 8'd0, 8'd0, RESULT_UNUSED},
    '{ROW_REG_WRITE, CFG_SPARE_7, ALL_ONES, 8'd0, 8'd0, 8'd0, RESULT_UNUSED},
    '{ROW_PIXEL, CFG_MEAN_0, NO_DATA, 8'd200, 8'd200, 8'd200, RESULT_UNUSED},
    '{ROW_REG_WRITE, CFG_REJECT_LIMIT, NO_DATA, 8'd0, 8'd0, 8'd0, RESULT_UNUSED},
    '{ROW_PIXEL_KNOWN, CFG_MEAN_0, NO_DATA, 8'd50, 8'd50, 8'd50, RESULT_NO_MATCH},
    '{ROW_PIXEL_KNOWN, CFG_MEAN_0, NO_DATA, 8'd0, 8'd0, 8'd0, RESULT_NO_MATCH},
    // upper write bits fall off the limit register
    '{ROW_REG_WRITE, CFG_REJECT_LIMIT, ALL_ONES, 8'd0, 8'd0, 8'd0, RESULT_UNUSED},
    '{ROW_REG_WRITE, CFG_MEAN_0, ALL_ONES, 8'd0, 8'd0, 8'd0, RESULT_UNUSED},
    '{ROW_PIXEL, CFG_MEAN_0, NO_DATA, 8'd0, 8'd0, 8'd0, RESULT_UNUSED},
    '{ROW_PIXEL, CFG_MEAN_0, NO_DATA, 8'd255, 8'd255, 8'd255, RESULT_UNUSED},
    '{ROW_PIXEL, CFG_MEAN_0, NO_DATA, 8'd255, 8'd0, 8'd255, RESULT_UNUSED}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                               in_valid       = 1'b0;
  logic                               in_ready;
  ncmc_pkg::sample_t                  in_pixel_red   = '0;
  ncmc_pkg::sample_t                  in_pixel_green = '0;
  ncmc_pkg::sample_t                  in_pixel_blue  = '0;
  logic                               out_valid;
  logic                               out_ready      = 1'b0;
  logic [ncmc_pkg::IDX_W-1:0]         out_class_index;
  logic                               out_no_match;
  logic [ncmc_pkg::COLOR_W-1:0]       out_label_blue;
  logic [ncmc_pkg::COLOR_W-1:0]       out_label_green;
  logic [ncmc_pkg::COLOR_W-1:0]       out_label_red;
  logic                               cfg_valid      = 1'b0;
  logic                               cfg_ready;
  logic [ncmc_pkg::CFG_IDX_W-1:0]     cfg_index      = '0;
  ncmc_pkg::mean_t                    cfg_wdata      = '0;

  ncmc_pkg::mean_t class_means [5];
  logic [31:0]     reject_limit;
  class_result_t   pending_labels [$];
  int              mismatch_count = 0;
  logic            steady         = 1'b0;
  logic            long_hold      = 1'b0;

  nearest_class_mean_pixel_classifier #(
    .NUM_CLASSES (NUM_CLASSES)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_red    (in_pixel_red),
    .in_pixel_green  (in_pixel_green),
    .in_pixel_blue   (in_pixel_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_class_index (out_class_index),
    .out_no_match    (out_no_match),
    .out_label_blue  (out_label_blue),
    .out_label_green (out_label_green),
    .out_label_red   (out_label_red),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Exact squared distances in 64 bits; first strictly smaller distance below the limit wins.
  function automatic class_result_t classify_pixel(ncmc_pkg::sample_t red,
                                                   ncmc_pkg::sample_t green,
                                                   ncmc_pkg::sample_t blue);
    logic [63:0]   best;
    logic [63:0]   dist_sum;
    logic [63:0]   scaled;
    logic [63:0]   diff;
    logic [14:0]   band;
    logic [7:0]    px [3];
    int            win;
    class_result_t res;
    px[0] = red;
    px[1] = green;
    px[2] = blue;
    best  = 64'(reject_limit);
    win   = -1;
    for (int k = 0; k < NUM_CLASSES && k < ncmc_pkg::MAX_CLASSES; k++) begin
      dist_sum = '0;
      for (int b = 0; b < 3; b++) begin
        band     = class_means[k][b*ncmc_pkg::BAND_W +: ncmc_pkg::BAND_W];
        scaled   = 64'(px[b]) * SCALE;
        diff     = (scaled >= 64'(band)) ? scaled - 64'(band) : 64'(band) - scaled;
        dist_sum = dist_sum + diff * diff;
      end
      if (dist_sum < best) begin
        best = dist_sum;
        win  = k;
      end
    end
    res = '0;
    if (win < 0) begin
      res.no_match = 1'b1;
    end else begin
      res.class_index = win[2:0];
      {res.label_blue, res.label_green, res.label_red} = LABEL_BGR[win];
    end
    return res;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Enter and leave at a falling edge; valid stays high into the next word when there is no gap.
  task automatic send_pixel(input ncmc_pkg::sample_t red, input ncmc_pkg::sample_t green,
                            input ncmc_pkg::sample_t blue, input logic use_known,
                            input class_result_t known);
    int            gap;
    class_result_t due;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_red   <= red;
    in_pixel_green <= green;
    in_pixel_blue  <= blue;
    do @(posedge clk); while (in_ready !== 1'b1);
    due = use_known ? known : classify_pixel(red, green, blue);
    pending_labels.insert(pending_labels.size(), due);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input ncmc_pkg::mean_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx <= CFG_MEAN_4) begin
      class_means[idx] = data;
    end else if (idx == CFG_REJECT_LIMIT) begin
      reject_limit = data[ncmc_pkg::LIMIT_W-1:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every pending word, then let the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_labels.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  initial begin : result_sink
    class_result_t want;
    int            stall;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 10);
      if (long_hold) begin
        stall     = HOLD_CYCLES;
        long_hold = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_labels.size() == 0) begin
        $display("%0t: unexpected word, expected none got class %0d no_match %0b",
                 $time, out_class_index, out_no_match);
        mismatch_count++;
      end else begin
        want = pending_labels.pop_front();
        check_field("class_index", 8'(want.class_index), 8'(out_class_index));
        check_field("no_match", 8'(want.no_match), 8'(out_no_match));
        check_field("label_blue", want.label_blue, out_label_blue);
        check_field("label_green", want.label_green, out_label_green);
        check_field("label_red", want.label_red, out_label_red);
      end
      @(negedge clk);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("nearest_class_mean_pixel_classifier_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    stim_row_t         row;
    ncmc_pkg::mean_t   mean;
    logic [31:0]       limit;
    logic [7:0]        px [3];
    int                centre;
    int                sel;
    int                pick;
    for (int k = 0; k < 5; k++) class_means[k] = '0;
    reject_limit = RESET_REJECT_LIMIT;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      row = DIRECTED_ROWS[i];
      case (row.kind)
        ROW_REG_WRITE: begin
          wait_idle();
          write_reg(row.reg_sel, row.wdata);
        end
        ROW_PIXEL_KNOWN: send_pixel(row.red, row.green, row.blue, 1'b1, row.known);
        default:         send_pixel(row.red, row.green, row.blue, 1'b0, RESULT_UNUSED);
      endcase
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      for (int k = 0; k < 5; k++) begin
        if (phase == 0) begin
          mean = ALL_ONES;
        end else if (k > 0 && $urandom_range(0, 3) == 0) begin
          // duplicate an earlier mean to force ties
          mean = class_means[$urandom_range(0, k - 1)];
        end else begin
          for (int b = 0; b < 3; b++) begin
            case ($urandom_range(0, 7))
              0:       mean[b*15 +: 15] = 15'd0;
              1:       mean[b*15 +: 15] = 15'h7FFF;
              2:       mean[b*15 +: 15] = 15'($urandom_range(0, 32767));
              3:       mean[b*15 +: 15] = 15'(SCALE * $urandom_range(0, 255));
              default: mean[b*15 +: 15] = 15'($urandom_range(0, 25500));
            endcase
          end
        end
        write_reg(cfg_reg_e'(k), mean);
      end
      if ($urandom_range(0, 1)) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_7 : CFG_SPARE_6,
                  {13'($urandom), $urandom});
      end
      if (phase == 0) begin
        limit = '1;
      end else if (phase == 1) begin
        limit = '0;
      end else begin
        case ($urandom_range(0, 5))
          0:       limit = '1;
          1:       limit = $urandom;
          2:       limit = $urandom_range(0, 2000000);
          3:       limit = $urandom_range(0, 100000000);
          // exact grid distances so some words land right on the limit
          4:       limit = 32'(10000 * $urandom_range(0, 300));
          default: limit = RESET_REJECT_LIMIT;
        endcase
      end
      write_reg(CFG_REJECT_LIMIT, {13'($urandom), limit});

      if (phase == HOLD_PHASE) long_hold = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        steady = ((n % 100) < 20) || (phase == HOLD_PHASE && n < 60);
        sel    = $urandom_range(0, 9);
        pick   = $urandom_range(0, 4);
        for (int b = 0; b < 3; b++) begin
          if (sel == 0) begin
            px[b] = 8'($urandom);
          end else if (sel == 1) begin
            px[b] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          end else begin
            // land near a configured mean
            centre = int'(class_means[pick][b*15 +: 15]) / SCALE
                     + int'($urandom_range(0, 12)) - 6;
            if (centre < 0) centre = 0;
            if (centre > 255) centre = 255;
            px[b] = 8'(centre);
          end
        end
        send_pixel(px[0], px[1], px[2], 1'b0, RESULT_UNUSED);
      end
      steady = 1'b0;
    end

    wait_idle();
    repeat (2 * LATENCY) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("nearest_class_mean_pixel_classifier_tb: PASS");
    end else begin
      $display("nearest_class_mean_pixel_classifier_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ncmc_pkg.sv
sv/ncmc_dist.sv
sv/ncmc_select.sv
sv/nearest_class_mean_pixel_classifier.sv
test/nearest_class_mean_pixel_classifier_tb.sv
